// ----- rtl/core/tw_pkg.sv -----
// shared types and constants of the active-to-simple time warp
`default_nettype none
package tw_pkg;
	localparam int FRAC_BITS = 16;
	localparam int TAU_W     = 31;
	localparam int DUR_W     = 30;
	localparam int FR_W      = FRAC_BITS + 1;
	localparam int SPD_W     = 16;
	localparam int AD_W      = 31;
	localparam int OUT_W     = 32;
	localparam int DD_W      = FRAC_BITS + 2;
	localparam int CFG_W     = 31;
	localparam int IDX_W     = 3;
	localparam int MAG_W     = 40;
	localparam int PER_W     = DUR_W + 1;
	localparam int PRD_W     = FR_W + DUR_W;
	localparam int NUMB_W    = 2 * DUR_W + FRAC_BITS;
	localparam int NUMC_W    = OUT_W + FRAC_BITS;
	localparam logic [FR_W-1:0] ONE = FR_W'(1) << FRAC_BITS;

	localparam logic [IDX_W-1:0] REG_SIMPLE_DUR = 3'd0;
	localparam logic [IDX_W-1:0] REG_AUTO_REV   = 3'd1;
	localparam logic [IDX_W-1:0] REG_ACCEL      = 3'd2;
	localparam logic [IDX_W-1:0] REG_DECEL      = 3'd3;
	localparam logic [IDX_W-1:0] REG_SPEED      = 3'd4;
	localparam logic [IDX_W-1:0] REG_ACTIVE_DUR = 3'd5;

	typedef enum logic [1:0] {
		SEG_ACCEL,
		SEG_DECEL,
		SEG_RUN
	} seg_t;

	typedef struct packed {
		logic [DUR_W-1:0]        dur;
		logic                    auto_rev;
		logic [FR_W-1:0]         acc;
		logic [FR_W-1:0]         dec;
		logic [DD_W-1:0]         dd;
		logic signed [SPD_W-1:0] speed;
		logic [AD_W-1:0]         act_dur;
	} cfg_t;
endpackage
`default_nettype wire

// ----- rtl/core/tw_in_if.sv -----
// request channel carrying one active time
`default_nettype none
interface tw_in_if;
	logic                         valid;
	logic                         ready;
	logic [tw_pkg::TAU_W-1:0]     active_time;
	modport source (output valid, output active_time, input ready);
	modport sink (input valid, input active_time, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tw_out_if.sv -----
// request channel carrying one filtered time and iteration
`default_nettype none
interface tw_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [tw_pkg::OUT_W-1:0] filtered_time;
	logic signed [tw_pkg::OUT_W-1:0] iteration;
	modport source (output valid, output filtered_time, output iteration, input ready);
	modport sink (input valid, input filtered_time, input iteration, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/active_to_simple_time_warp_unit.sv -----
// Active-to-simple time warp: one active time in, one filtered simple time and
// iteration out per request. The datapath is fully pipelined and accepts one
// request every cycle while the output is not stalled; from acceptance a request
// passes 3 speed-scaling stages, a 40-stage divider for the repeat count and
// remainder, 5 fold and segment-setup stages, two 32-stage dividers for the
// accelerate/decelerate curve and its rate scaling, and the output register.
// Configuration is taken from a plain write port and must only change while
// no request is in flight.
`default_nettype none
module active_to_simple_time_warp_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [tw_pkg::IDX_W-1:0]  cfg_idx,
	input  wire logic [tw_pkg::CFG_W-1:0]  cfg_data,
	tw_in_if.sink                          sample,
	tw_out_if.source                       result
);
	localparam int F = tw_pkg::FRAC_BITS;

	logic [tw_pkg::DUR_W-1:0]        dur_q;
	logic                            auto_rev_q;
	logic [tw_pkg::FR_W-1:0]         acc_q, dec_q;
	logic signed [tw_pkg::SPD_W-1:0] speed_q;
	logic [tw_pkg::AD_W-1:0]         act_dur_q;

	tw_pkg::cfg_t                    cfg;
	logic [tw_pkg::DD_W-1:0]         frac_sum;
	logic                            frac_ok;

	logic                            adv;
	logic                            res_vld_q;
	logic signed [tw_pkg::OUT_W-1:0] res_time_q, res_iter_q;

	logic                            fr_vld, fr_neg;
	logic [tw_pkg::MAG_W-1:0]        fr_mag;
	logic                            da_vld, da_neg;
	logic [tw_pkg::MAG_W-1:0]        da_quo;
	logic [tw_pkg::PER_W-1:0]        da_rem, period;
	logic                            md_vld;
	logic [tw_pkg::NUMB_W-1:0]       md_num;
	logic [tw_pkg::PRD_W-1:0]        md_den;
	tw_pkg::seg_t                    md_seg;
	logic [tw_pkg::OUT_W-1:0]        md_iter;
	logic                            db_vld;
	logic [tw_pkg::OUT_W-1:0]        db_quo;
	logic [tw_pkg::PRD_W-1:0]        db_rem;
	logic [33:0]                     db_side;
	logic                            dc_vld;
	logic [tw_pkg::OUT_W-1:0]        dc_quo;
	logic [tw_pkg::DD_W-1:0]         dc_rem;
	logic [65:0]                     dc_side;
	tw_pkg::seg_t                    fin_seg;
	logic [tw_pkg::OUT_W-1:0]        fin_iter, fin_run, tsf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q      <= tw_pkg::DUR_W'(65536);
			auto_rev_q <= 1'b0;
			acc_q      <= '0;
			dec_q      <= '0;
			speed_q    <= 16'sd256;
			act_dur_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tw_pkg::REG_SIMPLE_DUR: dur_q      <= cfg_data[tw_pkg::DUR_W-1:0];
				tw_pkg::REG_AUTO_REV:   auto_rev_q <= cfg_data[0];
				tw_pkg::REG_ACCEL:      acc_q      <= cfg_data[tw_pkg::FR_W-1:0];
				tw_pkg::REG_DECEL:      dec_q      <= cfg_data[tw_pkg::FR_W-1:0];
				tw_pkg::REG_SPEED:      speed_q    <= cfg_data[tw_pkg::SPD_W-1:0];
				tw_pkg::REG_ACTIVE_DUR: act_dur_q  <= cfg_data[tw_pkg::AD_W-1:0];
				default: ;
			endcase
		end
	end

	// fractions summing past one are both dropped; zero duration acts as one lsb
	assign frac_sum     = {1'b0, acc_q} + {1'b0, dec_q};
	assign frac_ok      = frac_sum <= {1'b0, tw_pkg::ONE};
	assign cfg.dur      = (dur_q == '0) ? tw_pkg::DUR_W'(1) : dur_q;
	assign cfg.auto_rev = auto_rev_q;
	assign cfg.acc      = frac_ok ? acc_q : '0;
	assign cfg.dec      = frac_ok ? dec_q : '0;
	assign cfg.dd       = {tw_pkg::ONE, 1'b0} - {1'b0, cfg.acc} - {1'b0, cfg.dec};
	assign cfg.speed    = speed_q;
	assign cfg.act_dur  = act_dur_q;

	assign period = cfg.auto_rev ? {cfg.dur, 1'b0} : {1'b0, cfg.dur};

	assign adv          = !res_vld_q || result.ready;
	assign sample.ready = adv;

	tw_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (sample.valid),
		.tau_i  (sample.active_time),
		.cfg    (cfg),
		.vld_o  (fr_vld),
		.mag_o  (fr_mag),
		.neg_o  (fr_neg)
	);

	tw_div #(
		.NUM_W  (tw_pkg::MAG_W),
		.DEN_W  (tw_pkg::PER_W),
		.Q_W    (tw_pkg::MAG_W),
		.SIDE_W (1)
	) u_div_rep (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (fr_vld),
		.num_i  (fr_mag),
		.den_i  (period),
		.side_i (fr_neg),
		.vld_o  (da_vld),
		.quo_o  (da_quo),
		.rem_o  (da_rem),
		.side_o (da_neg)
	);

	tw_mid u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (da_vld),
		.quo_i  (da_quo),
		.rem_i  (da_rem),
		.neg_i  (da_neg),
		.cfg    (cfg),
		.vld_o  (md_vld),
		.num_o  (md_num),
		.den_o  (md_den),
		.seg_o  (md_seg),
		.iter_o (md_iter)
	);

	tw_div #(
		.NUM_W  (tw_pkg::NUMB_W),
		.DEN_W  (tw_pkg::PRD_W),
		.Q_W    (tw_pkg::OUT_W),
		.SIDE_W (34)
	) u_div_curve (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (md_vld),
		.num_i  (md_num),
		.den_i  (md_den),
		.side_i ({md_seg, md_iter}),
		.vld_o  (db_vld),
		.quo_o  (db_quo),
		.rem_o  (db_rem),
		.side_o (db_side)
	);

	// rate scaling by one over the mean speed of the curve
	tw_div #(
		.NUM_W  (tw_pkg::NUMC_W),
		.DEN_W  (tw_pkg::DD_W),
		.Q_W    (tw_pkg::OUT_W),
		.SIDE_W (66)
	) u_div_rate (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (db_vld),
		.num_i  ({db_quo, {F{1'b0}}}),
		.den_i  (cfg.dd),
		.side_i ({db_side, db_quo}),
		.vld_o  (dc_vld),
		.quo_o  (dc_quo),
		.rem_o  (dc_rem),
		.side_o (dc_side)
	);

	assign fin_seg  = tw_pkg::seg_t'(dc_side[65:64]);
	assign fin_iter = dc_side[63:32];
	assign fin_run  = dc_side[31:0];

	always_comb begin
		unique case (fin_seg)
			tw_pkg::SEG_ACCEL: tsf = dc_quo;
			tw_pkg::SEG_DECEL: tsf = (dc_quo > {2'b0, cfg.dur}) ? '0 : {2'b0, cfg.dur} - dc_quo;
			default:           tsf = (fin_run > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : fin_run;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else if (adv)
			res_vld_q <= dc_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_time_q <= $signed(tsf);
			res_iter_q <= $signed(fin_iter);
		end
	end

	assign result.valid         = res_vld_q;
	assign result.filtered_time = res_time_q;
	assign result.iteration     = res_iter_q;

	logic unused_rem;
	assign unused_rem = ^{db_rem, dc_rem};
endmodule
`default_nettype wire

// ----- rtl/core/tw_front.sv -----
// speed scaling stages: scaled active time split into sign and magnitude
`default_nettype none
module tw_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     adv,
	input  wire logic                     vld_i,
	input  wire logic [tw_pkg::TAU_W-1:0] tau_i,
	input  wire tw_pkg::cfg_t             cfg,
	output logic                          vld_o,
	output logic [tw_pkg::MAG_W-1:0]      mag_o,
	output logic                          neg_o
);
	logic [tw_pkg::SPD_W-1:0] spd_mag;
	logic                     bwd;
	logic                     vld_s1, vld_s2, vld_s3;
	logic [46:0]              prod_s1;
	logic                     bwd_s1;
	logic signed [40:0]       taf_s2;
	logic [tw_pkg::MAG_W-1:0] mag_s3;
	logic                     neg_s3;

	assign bwd     = cfg.speed[tw_pkg::SPD_W-1] || (cfg.speed == '0);
	assign spd_mag = cfg.speed[tw_pkg::SPD_W-1] ? 16'(-cfg.speed) : 16'(cfg.speed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= {16'b0, tau_i} * {31'b0, spd_mag};
			bwd_s1  <= bwd;
			// backward play counts down from the active duration
			if (bwd_s1)
				taf_s2 <= $signed({10'b0, cfg.act_dur}) - $signed({2'b0, prod_s1[46:8]});
			else
				taf_s2 <= $signed({2'b0, prod_s1[46:8]});
			neg_s3 <= taf_s2[40];
			mag_s3 <= taf_s2[40] ? 40'(-taf_s2) : taf_s2[39:0];
		end
	end

	assign vld_o = vld_s3;
	assign mag_o = mag_s3;
	assign neg_o = neg_s3;
endmodule
`default_nettype wire

// ----- rtl/core/tw_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module tw_div #(
	parameter int NUM_W  = 40,
	parameter int DEN_W  = 31,
	parameter int Q_W    = 40,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              vld_i,
	input  wire logic [NUM_W-1:0]  num_i,
	input  wire logic [DEN_W-1:0]  den_i,
	input  wire logic [SIDE_W-1:0] side_i,
	output logic                   vld_o,
	output logic [Q_W-1:0]         quo_o,
	output logic [DEN_W-1:0]       rem_o,
	output logic [SIDE_W-1:0]      side_o
);
	logic              vld_s  [Q_W+1];
	logic [DEN_W-1:0]  rem_s  [Q_W+1];
	logic [Q_W-1:0]    lo_s   [Q_W+1];
	logic [DEN_W-1:0]  den_s  [Q_W+1];
	logic [SIDE_W-1:0] side_s [Q_W+1];

	// the upper dividend bits are known to sit below the divisor
	always_comb begin
		vld_s[0]  = vld_i;
		rem_s[0]  = DEN_W'(num_i >> Q_W);
		lo_s[0]   = num_i[Q_W-1:0];
		den_s[0]  = den_i;
		side_s[0] = side_i;
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [DEN_W:0] sh;
		logic           ge;
		assign sh = {rem_s[k], lo_s[k][Q_W-1]};
		assign ge = sh >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (adv)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= ge ? DEN_W'(sh - {1'b0, den_s[k]}) : sh[DEN_W-1:0];
				lo_s[k+1]   <= {lo_s[k][Q_W-2:0], ge};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld_o  = vld_s[Q_W];
	assign quo_o  = lo_s[Q_W];
	assign rem_o  = rem_s[Q_W];
	assign side_o = side_s[Q_W];
endmodule
`default_nettype wire

// ----- rtl/core/tw_mid.sv -----
// iteration, floor remainder, mirroring and segment setup for the warp division
`default_nettype none
module tw_mid (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      adv,
	input  wire logic                      vld_i,
	input  wire logic [tw_pkg::MAG_W-1:0]  quo_i,
	input  wire logic [tw_pkg::PER_W-1:0]  rem_i,
	input  wire logic                      neg_i,
	input  wire tw_pkg::cfg_t              cfg,
	output logic                           vld_o,
	output logic [tw_pkg::NUMB_W-1:0]      num_o,
	output logic [tw_pkg::PRD_W-1:0]       den_o,
	output tw_pkg::seg_t                   seg_o,
	output logic [tw_pkg::OUT_W-1:0]       iter_o
);
	localparam int F = tw_pkg::FRAC_BITS;

	logic [tw_pkg::PER_W-1:0]    period;
	logic                        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [tw_pkg::OUT_W-1:0]    iter_s1, iter_s2, iter_s3, iter_s4, iter_s5;
	logic [tw_pkg::PER_W-1:0]    m_s1;
	logic [tw_pkg::DUR_W-1:0]    t_s2, t_s3, t_s4;
	logic [2*tw_pkg::DUR_W-1:0]  tt_s3, tt_s4, uu_s4;
	logic [tw_pkg::DUR_W-1:0]    u_s3;
	logic [tw_pkg::PRD_W-1:0]    accd_s3, decd_s3, lim_s3, accd_s4, decd_s4;
	tw_pkg::seg_t                seg_s4, seg_s5;
	logic [tw_pkg::NUMB_W-1:0]   num_s5;
	logic [tw_pkg::PRD_W-1:0]    den_s5;
	logic [tw_pkg::PRD_W-1:0]    run_num;

	assign period  = cfg.auto_rev ? {cfg.dur, 1'b0} : {1'b0, cfg.dur};
	assign run_num = {t_s4, {(F+1){1'b0}}} - accd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// truncated quotient with saturation, floor remainder
			if (!neg_i)
				iter_s1 <= (quo_i > 40'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_i[31:0];
			else
				iter_s1 <= (quo_i > 40'h8000_0000) ? 32'h8000_0000 : (~quo_i[31:0]) + 32'd1;
			m_s1 <= (neg_i && rem_i != '0) ? period - rem_i : rem_i;

			iter_s2 <= iter_s1;
			// reversed half plays mirrored
			if (cfg.auto_rev && m_s1 >= {1'b0, cfg.dur})
				t_s2 <= tw_pkg::DUR_W'(period - m_s1);
			else
				t_s2 <= m_s1[tw_pkg::DUR_W-1:0];

			iter_s3 <= iter_s2;
			t_s3    <= t_s2;
			tt_s3   <= {30'b0, t_s2} * {30'b0, t_s2};
			u_s3    <= cfg.dur - t_s2;
			accd_s3 <= {30'b0, cfg.acc} * {17'b0, cfg.dur};
			decd_s3 <= {30'b0, cfg.dec} * {17'b0, cfg.dur};
			lim_s3  <= {30'b0, tw_pkg::ONE - cfg.dec} * {17'b0, cfg.dur};

			iter_s4 <= iter_s3;
			t_s4    <= t_s3;
			tt_s4   <= tt_s3;
			uu_s4   <= {30'b0, u_s3} * {30'b0, u_s3};
			accd_s4 <= accd_s3;
			decd_s4 <= decd_s3;
			if ({1'b0, t_s3, {F{1'b0}}} < accd_s3)
				seg_s4 <= tw_pkg::SEG_ACCEL;
			else if ({1'b0, t_s3, {F{1'b0}}} > lim_s3)
				seg_s4 <= tw_pkg::SEG_DECEL;
			else
				seg_s4 <= tw_pkg::SEG_RUN;

			iter_s5 <= iter_s4;
			seg_s5  <= seg_s4;
			unique case (seg_s4)
				tw_pkg::SEG_ACCEL: begin
					num_s5 <= {tt_s4, {F{1'b0}}};
					den_s5 <= accd_s4;
				end
				tw_pkg::SEG_DECEL: begin
					num_s5 <= {uu_s4, {F{1'b0}}};
					den_s5 <= decd_s4;
				end
				default: begin
					num_s5 <= tw_pkg::NUMB_W'(run_num);
					den_s5 <= tw_pkg::PRD_W'(cfg.dd);
				end
			endcase
		end
	end

	assign vld_o  = vld_s5;
	assign num_o  = num_s5;
	assign den_o  = den_s5;
	assign seg_o  = seg_s5;
	assign iter_o = iter_s5;
endmodule
`default_nettype wire
